/* hdl/ishm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ishm_pkg
// Shared widths, constants, types and helper functions of the IMU stream
// health monitor.
// ----------------------------------------------------------------------------
package ishm_pkg;

  // counter width of the sample and out-of-band counters
  localparam int CNT_BITS = 32;
  localparam int OUT_W    = 32;

  localparam int STAMP_W = 63;
  localparam int Z_W     = 24;
  localparam int PER_W   = 20;
  localparam int RATE_W  = 24;
  localparam int PCT_W   = 7;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // shared multiplier: one 32-bit chunk of a wide word times a 30-bit operand
  localparam int CHUNK_W = 32;
  localparam int MULB_W  = 30;
  localparam int WORD_W  = 2 * CHUNK_W;
  localparam int MULP_W  = CHUNK_W + MULB_W;
  localparam int PROD_W  = (((CNT_BITS + MULB_W) > (STAMP_W + RATE_W)) ?
                            (CNT_BITS + MULB_W) : (STAMP_W + RATE_W)) + 1;
  localparam int PCT_PROD_W = CNT_BITS + PCT_W;

  // microseconds per second times millihertz per hertz
  localparam logic [MULB_W-1:0] RATE_SCALE = MULB_W'(1000000000);
  localparam logic [PCT_W-1:0]  PCT_SCALE  = PCT_W'(100);

  // z thresholds in milli-units
  localparam logic signed [Z_W-1:0] Z_UNIT_SPLIT = 5500;
  localparam logic signed [Z_W-1:0] Z_G_HI       = 1250;
  localparam logic signed [Z_W-1:0] Z_G_LO       = 750;
  localparam logic signed [Z_W-1:0] Z_MS_HI      = 12250;
  localparam logic signed [Z_W-1:0] Z_MS_LO      = 7350;

  typedef struct packed {
    logic [PER_W-1:0]  nominal;
    logic [PER_W-1:0]  period_tol;
    logic [RATE_W-1:0] target;
    logic [RATE_W-1:0] rate_tol;
    logic [PCT_W-1:0]  limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_NONE,
    ST_LOAD,
    ST_S_DIFF,
    ST_S_DEV,
    ST_S_COMMIT,
    ST_F_DUR,
    ST_F_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_F_DIFF,
    ST_F_CMP,
    ST_OUT
  } step_t;

  // which product the multiplier sequence builds
  typedef enum logic [1:0] {
    PR_A,   // (n - 1) * rate scale
    PR_B,   // target * duration
    PR_C    // tolerance * duration
  } prod_t;

  typedef struct packed {
    step_t step;
    prod_t prod;
  } cmd_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    sat_inc = (c != '1) ? c + CNT_BITS'(1) : c;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [CNT_BITS-1:0] c);
    logic [CNT_BITS-1:0] upper;
    upper = c >> OUT_W;
    if (upper != '0) begin
      sat_out = '1;
    end else begin
      sat_out = OUT_W'(c);
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/ishm_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ishm_regs
// APB register file: period, tolerance, rate target and range limit settings.
// ----------------------------------------------------------------------------
module ishm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ishm_pkg::ADDR_W-1:0] paddr,
  input  logic [ishm_pkg::DATA_W-1:0] pwdata,
  output logic [ishm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ishm_pkg::cfg_t             cfg
);

  typedef enum logic [2:0] {
    REG_NOMINAL = 3'd0,
    REG_PTOL    = 3'd1,
    REG_TARGET  = 3'd2,
    REG_RTOL    = 3'd3,
    REG_LIMIT   = 3'd4
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ishm_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal    <= ishm_pkg::PER_W'(10000);
      cfg.period_tol <= ishm_pkg::PER_W'(5000);
      cfg.target     <= ishm_pkg::RATE_W'(100000);
      cfg.rate_tol   <= ishm_pkg::RATE_W'(2500);
      cfg.limit      <= ishm_pkg::PCT_W'(5);
    end else if (wr) begin
      unique case (idx)
        REG_NOMINAL: cfg.nominal    <= pwdata[ishm_pkg::PER_W-1:0];
        REG_PTOL:    cfg.period_tol <= pwdata[ishm_pkg::PER_W-1:0];
        REG_TARGET:  cfg.target     <= pwdata[ishm_pkg::RATE_W-1:0];
        REG_RTOL:    cfg.rate_tol   <= pwdata[ishm_pkg::RATE_W-1:0];
        REG_LIMIT:   cfg.limit      <= pwdata[ishm_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NOMINAL: prdata = ishm_pkg::DATA_W'(cfg.nominal);
      REG_PTOL:    prdata = ishm_pkg::DATA_W'(cfg.period_tol);
      REG_TARGET:  prdata = ishm_pkg::DATA_W'(cfg.target);
      REG_RTOL:    prdata = ishm_pkg::DATA_W'(cfg.rate_tol);
      REG_LIMIT:   prdata = ishm_pkg::DATA_W'(cfg.limit);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/ishm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ishm_ctrl
// Sequencer: steps the datapath through a sample update or the end-of-stream
// checks and owns the output valid.
// ----------------------------------------------------------------------------
module ishm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ishm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    IDLE,
    S_DIFF,
    S_DEV,
    S_COMMIT,
    F_DUR,
    F_ABS,
    M_LO,
    M_HI,
    M_SUM,
    F_DIFF,
    F_CMP,
    EMIT
  } state_t;

  state_t          state;
  ishm_pkg::prod_t prod;
  logic            accept;
  logic            out_free;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.prod = prod;
    unique case (state)
      IDLE:     cmd.step = accept ? ishm_pkg::ST_LOAD : ishm_pkg::ST_NONE;
      S_DIFF:   cmd.step = ishm_pkg::ST_S_DIFF;
      S_DEV:    cmd.step = ishm_pkg::ST_S_DEV;
      S_COMMIT: cmd.step = ishm_pkg::ST_S_COMMIT;
      F_DUR:    cmd.step = ishm_pkg::ST_F_DUR;
      F_ABS:    cmd.step = ishm_pkg::ST_F_ABS;
      M_LO:     cmd.step = ishm_pkg::ST_MUL_LO;
      M_HI:     cmd.step = ishm_pkg::ST_MUL_HI;
      M_SUM:    cmd.step = ishm_pkg::ST_MUL_SUM;
      F_DIFF:   cmd.step = ishm_pkg::ST_F_DIFF;
      F_CMP:    cmd.step = ishm_pkg::ST_F_CMP;
      EMIT:     cmd.step = out_free ? ishm_pkg::ST_OUT : ishm_pkg::ST_NONE;
      default:  cmd.step = ishm_pkg::ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      prod      <= ishm_pkg::PR_A;
      out_valid <= 1'b0;
    end else begin
      if (state == EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= op ? F_DUR : S_DIFF;
          end
        end
        S_DIFF:   state <= S_DEV;
        S_DEV:    state <= S_COMMIT;
        S_COMMIT: state <= EMIT;
        F_DUR:    state <= F_ABS;
        F_ABS: begin
          state <= M_LO;
          prod  <= ishm_pkg::PR_A;
        end
        M_LO:     state <= M_HI;
        M_HI:     state <= M_SUM;
        M_SUM: begin
          // three products: rate numerator, target and tolerance terms
          priority if (prod == ishm_pkg::PR_C) begin
            state <= F_DIFF;
          end else if (prod == ishm_pkg::PR_B) begin
            state <= M_LO;
            prod  <= ishm_pkg::PR_C;
          end else begin
            state <= M_LO;
            prod  <= ishm_pkg::PR_B;
          end
        end
        F_DIFF:   state <= F_CMP;
        F_CMP:    state <= EMIT;
        EMIT: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default:  state <= IDLE;
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == EMIT))
    else $error("result raised outside the emit step");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    state == EMIT && !out_free |=> state == EMIT && out_valid)
    else $error("pending result overwritten or dropped");

endmodule
`default_nettype wire

/* hdl/ishm_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ishm_dp
// Datapath: monitor state, spacing and band checks, shared chunked multiplier
// for the end-of-stream rate check, and the result register.
// ----------------------------------------------------------------------------
module ishm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ishm_pkg::cmd_t                      cmd,
  input  ishm_pkg::cfg_t                      cfg,
  input  logic                                op,
  input  logic [ishm_pkg::STAMP_W-1:0]        stamp_us,
  input  logic [ishm_pkg::STAMP_W-1:0]        arrival_us,
  input  logic signed [ishm_pkg::Z_W-1:0]     accel_z_milli,
  input  logic                                orientation_ok,
  output logic                                is_final,
  output logic                                order_error,
  output logic                                spacing_error,
  output logic                                axis_error,
  output logic                                unit_known,
  output logic                                unit_is_g,
  output logic                                rate_error,
  output logic                                range_error,
  output logic                                no_data,
  output logic [ishm_pkg::OUT_W-1:0]          total_samples,
  output logic [ishm_pkg::OUT_W-1:0]          out_of_band
);

  localparam int SW = ishm_pkg::STAMP_W;

  // captured request
  logic                          op_r;
  logic [SW-1:0]                 stamp_r;
  logic [SW-1:0]                 arrival_r;
  logic signed [ishm_pkg::Z_W-1:0] z_r;
  logic                          ook_r;

  // monitor state
  logic [ishm_pkg::CNT_BITS-1:0] sample_count;
  logic [ishm_pkg::CNT_BITS-1:0] exceed_count;
  logic [SW-1:0]                 last_stamp;
  logic [SW-1:0]                 first_arrival;
  logic [SW-1:0]                 last_arrival;
  logic                          order_flag;
  logic                          spacing_flag;
  logic                          axis_flag;
  logic                          unit_set;
  logic                          unit_g;

  // work registers
  logic signed [SW:0]            diff;
  logic signed [SW+1:0]          dev_x;
  logic signed [SW:0]            dur;
  logic [SW-1:0]                 dmag;
  logic                          dneg;
  logic                          dzero;
  logic [ishm_pkg::MULP_W-1:0]   p;
  logic [ishm_pkg::PROD_W-1:0]   acc;
  logic [ishm_pkg::PROD_W-1:0]   prod_a;
  logic [ishm_pkg::PROD_W-1:0]   prod_b;
  logic [ishm_pkg::PROD_W-1:0]   prod_c;
  logic signed [ishm_pkg::PROD_W:0] s;
  logic [ishm_pkg::PCT_PROD_W-1:0] ex_scaled;
  logic [ishm_pkg::PCT_PROD_W-1:0] lim_scaled;
  logic                          many;
  logic                          none;
  logic                          rate_bad;
  logic                          range_bad;

  // combinational helpers
  logic signed [SW+1:0]          diff_x;
  logic signed [SW+1:0]          nom_x;
  logic signed [SW+1:0]          tol_x;
  logic                          spacing_bad;
  logic                          first;
  logic                          g_sel;
  logic                          oob;
  logic [ishm_pkg::CNT_BITS-1:0] n1;
  logic [ishm_pkg::WORD_W-1:0]   mul_word;
  logic [ishm_pkg::CHUNK_W-1:0]  mul_chunk;
  logic [ishm_pkg::MULB_W-1:0]   mul_b;
  logic [ishm_pkg::MULP_W-1:0]   mul_p;
  logic [ishm_pkg::PROD_W-1:0]   acc_sum;
  logic signed [ishm_pkg::PROD_W:0] a_s;
  logic signed [ishm_pkg::PROD_W:0] b_s;
  logic signed [ishm_pkg::PROD_W:0] c_s;

  assign diff_x = (SW + 2)'(diff);
  assign nom_x  = (SW + 2)'(cfg.nominal);
  assign tol_x  = (SW + 2)'(cfg.period_tol);

  // dev_x holds |d - nominal| up to sign on forward steps, so test both sides
  assign spacing_bad = (last_stamp != '0) && ((dev_x > tol_x) || (dev_x < -tol_x));

  assign first = (sample_count == '0);
  assign g_sel = first ? (z_r < ishm_pkg::Z_UNIT_SPLIT) : unit_g;
  assign oob   = g_sel ? ((z_r >= ishm_pkg::Z_G_HI) || (z_r <= ishm_pkg::Z_G_LO))
                       : ((z_r >= ishm_pkg::Z_MS_HI) || (z_r <= ishm_pkg::Z_MS_LO));

  assign n1 = sample_count - ishm_pkg::CNT_BITS'(1);

  always_comb begin
    unique case (cmd.prod)
      ishm_pkg::PR_A: begin
        mul_word = ishm_pkg::WORD_W'(n1);
        mul_b    = ishm_pkg::RATE_SCALE;
      end
      ishm_pkg::PR_B: begin
        mul_word = ishm_pkg::WORD_W'(dmag);
        mul_b    = ishm_pkg::MULB_W'(cfg.target);
      end
      ishm_pkg::PR_C: begin
        mul_word = ishm_pkg::WORD_W'(dmag);
        mul_b    = ishm_pkg::MULB_W'(cfg.rate_tol);
      end
      default: begin
        mul_word = '0;
        mul_b    = '0;
      end
    endcase
  end

  assign mul_chunk = (cmd.step == ishm_pkg::ST_MUL_LO)
                   ? mul_word[ishm_pkg::CHUNK_W-1:0]
                   : mul_word[ishm_pkg::WORD_W-1:ishm_pkg::CHUNK_W];
  assign mul_p     = ishm_pkg::MULP_W'(mul_chunk) * ishm_pkg::MULP_W'(mul_b);
  assign acc_sum   = acc + (ishm_pkg::PROD_W'(p) << ishm_pkg::CHUNK_W);

  assign a_s = (ishm_pkg::PROD_W + 1)'(prod_a);
  assign b_s = (ishm_pkg::PROD_W + 1)'(prod_b);
  assign c_s = (ishm_pkg::PROD_W + 1)'(prod_c);

  // monitor state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      exceed_count  <= '0;
      last_stamp    <= '0;
      first_arrival <= '0;
      last_arrival  <= '0;
      order_flag    <= 1'b0;
      spacing_flag  <= 1'b0;
      axis_flag     <= 1'b0;
      unit_set      <= 1'b0;
      unit_g        <= 1'b0;
    end else if (cmd.step == ishm_pkg::ST_S_COMMIT) begin
      if (first) begin
        first_arrival <= arrival_r;
        axis_flag     <= !ook_r;
        unit_g        <= (z_r < ishm_pkg::Z_UNIT_SPLIT);
        unit_set      <= 1'b1;
      end
      last_arrival <= arrival_r;
      last_stamp   <= stamp_r;
      sample_count <= ishm_pkg::sat_inc(sample_count);
      if (oob) begin
        exceed_count <= ishm_pkg::sat_inc(exceed_count);
      end
      if (diff[SW]) begin
        order_flag <= 1'b1;
      end
      if (spacing_bad) begin
        spacing_flag <= 1'b1;
      end
    end
  end

  // request capture, work registers and result register
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      ishm_pkg::ST_LOAD: begin
        op_r      <= op;
        stamp_r   <= stamp_us;
        arrival_r <= arrival_us;
        z_r       <= accel_z_milli;
        ook_r     <= orientation_ok;
      end
      ishm_pkg::ST_S_DIFF: begin
        diff <= $signed({1'b0, stamp_r}) - $signed({1'b0, last_stamp});
      end
      ishm_pkg::ST_S_DEV: begin
        // backwards step: deviation is (last - stamp) + nominal
        dev_x <= diff[SW] ? (nom_x - diff_x) : (diff_x - nom_x);
      end
      ishm_pkg::ST_F_DUR: begin
        dur        <= $signed({1'b0, last_arrival}) - $signed({1'b0, first_arrival});
        ex_scaled  <= ishm_pkg::PCT_PROD_W'(exceed_count)
                    * ishm_pkg::PCT_PROD_W'(ishm_pkg::PCT_SCALE);
        lim_scaled <= ishm_pkg::PCT_PROD_W'(cfg.limit)
                    * ishm_pkg::PCT_PROD_W'(sample_count);
        many       <= (sample_count > ishm_pkg::CNT_BITS'(1));
        none       <= (sample_count == '0);
      end
      ishm_pkg::ST_F_ABS: begin
        dneg  <= dur[SW];
        dzero <= (dur == '0);
        dmag  <= dur[SW] ? SW'(-dur) : dur[SW-1:0];
      end
      ishm_pkg::ST_MUL_LO: begin
        p <= mul_p;
      end
      ishm_pkg::ST_MUL_HI: begin
        acc <= ishm_pkg::PROD_W'(p);
        p   <= mul_p;
      end
      ishm_pkg::ST_MUL_SUM: begin
        unique case (cmd.prod)
          ishm_pkg::PR_A: prod_a <= acc_sum;
          ishm_pkg::PR_B: prod_b <= acc_sum;
          ishm_pkg::PR_C: prod_c <= acc_sum;
          default: ;
        endcase
      end
      ishm_pkg::ST_F_DIFF: begin
        // negative duration: rate is negative, so |rate - target| scales to a + b
        s <= dneg ? (a_s + b_s) : (a_s - b_s);
      end
      ishm_pkg::ST_F_CMP: begin
        rate_bad  <= dzero || (dneg ? !(s < c_s) : !((s < c_s) && (s > -c_s)));
        range_bad <= (ex_scaled > lim_scaled);
      end
      ishm_pkg::ST_OUT: begin
        is_final      <= op_r;
        order_error   <= order_flag;
        spacing_error <= spacing_flag;
        axis_error    <= axis_flag;
        unit_known    <= unit_set;
        unit_is_g     <= unit_g;
        rate_error    <= op_r && many && rate_bad;
        range_error   <= op_r && many && range_bad;
        no_data       <= op_r && none;
        total_samples <= ishm_pkg::sat_out(sample_count);
        out_of_band   <= ishm_pkg::sat_out(exceed_count);
      end
      default: ;
    endcase
  end

  a_commit_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.step == ishm_pkg::ST_S_COMMIT |=> (sample_count != '0) && unit_set)
    else $error("sample committed without count or unit");

  a_order_sticky: assert property (@(posedge clk) disable iff (rst)
    order_flag |=> order_flag)
    else $error("order flag cleared outside reset");

endmodule
`default_nettype wire

/* hdl/imu_stream_health_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imu_stream_health_monitor
// Checks an IMU sample stream for stamp order, spacing, orientation, unit band
// and, on an end-of-stream request, average rate and out-of-band share.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall with op = 0 for a sample and op = 1
//   for end of stream. Every request yields exactly one result on
//   out_valid/out_stall. Settings are written over the APB port while idle.
//   A sample request passes through the 64-bit stamp subtract, deviation and
//   commit steps before out_valid rises; in_stall drops in the cycle out_valid
//   rises, so the next sample is taken only then. An end-of-stream request
//   passes through the duration, magnitude, product, difference and compare
//   steps: three wide products go through one 32x30 multiplier, two chunks
//   each, in a low, a high and a sum step per product.
//   in_stall is high while a request is in work. A result waits in the output
//   register while out_stall is high; the next request may be accepted then
//   but its result is held until the register is taken.
//   Synchronous reset clears all counters and flags and loads the default
//   settings; no result is pending after reset.
// ----------------------------------------------------------------------------
module imu_stream_health_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ishm_pkg::ADDR_W-1:0]      paddr,
  input  logic [ishm_pkg::DATA_W-1:0]      pwdata,
  output logic [ishm_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [ishm_pkg::STAMP_W-1:0]     stamp_us,
  input  logic [ishm_pkg::STAMP_W-1:0]     arrival_us,
  input  logic signed [ishm_pkg::Z_W-1:0]  accel_z_milli,
  input  logic                             orientation_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_final,
  output logic                             order_error,
  output logic                             spacing_error,
  output logic                             axis_error,
  output logic                             unit_known,
  output logic                             unit_is_g,
  output logic                             rate_error,
  output logic                             range_error,
  output logic                             no_data,
  output logic [ishm_pkg::OUT_W-1:0]       total_samples,
  output logic [ishm_pkg::OUT_W-1:0]       out_of_band
);

  ishm_pkg::cfg_t cfg;
  ishm_pkg::cmd_t cmd;

  ishm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ishm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ishm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .op             (op),
    .stamp_us       (stamp_us),
    .arrival_us     (arrival_us),
    .accel_z_milli  (accel_z_milli),
    .orientation_ok (orientation_ok),
    .is_final       (is_final),
    .order_error    (order_error),
    .spacing_error  (spacing_error),
    .axis_error     (axis_error),
    .unit_known     (unit_known),
    .unit_is_g      (unit_is_g),
    .rate_error     (rate_error),
    .range_error    (range_error),
    .no_data        (no_data),
    .total_samples  (total_samples),
    .out_of_band    (out_of_band)
  );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for imu_stream_health_monitor. A short directed run walks
// the stream corners (no data, single sample, zero and negative duration, band
// edges, field extremes, register extremes), then randomized sample streams
// with end-of-stream requests run under several settings and idle patterns.
// Every result is compared field by field against a behavioral predictor.
// ----------------------------------------------------------------------------
import ishm_pkg::*;

typedef enum logic {
  OP_SAMPLE = 1'b0,
  OP_END    = 1'b1
} op_e;

typedef enum int {
  REG_NOMINAL,
  REG_PERIOD_TOL,
  REG_TARGET,
  REG_RATE_TOL,
  REG_LIMIT
} cfg_reg_e;

typedef struct packed {
  op_e                      op;
  logic [STAMP_W-1:0]       stamp;
  logic [STAMP_W-1:0]       arrival;
  logic signed [Z_W-1:0]    accel_z;
  logic                     orient_ok;
} imu_req_t;

typedef struct packed {
  logic             is_final;
  logic             order_error;
  logic             spacing_error;
  logic             axis_error;
  logic             unit_known;
  logic             unit_is_g;
  logic             rate_error;
  logic             range_error;
  logic             no_data;
  logic [OUT_W-1:0] total_samples;
  logic [OUT_W-1:0] out_of_band;
} health_t;

localparam int     Z_SPLIT  = 5500;
localparam int     G_HI     = 1250;
localparam int     G_LO     = 750;
localparam int     MS_HI    = 12250;
localparam int     MS_LO    = 7350;
localparam longint NS_SCALE = 1000000000;

class imu_health_scoreboard;
  logic [PER_W-1:0]    nominal, period_tol;
  logic [RATE_W-1:0]   target, rate_tol;
  logic [PCT_W-1:0]    limit_pct;
  logic [CNT_BITS-1:0] n_samples, n_oob;
  logic [STAMP_W-1:0]  last_stamp, first_arr, last_arr;
  bit                  order_f, spacing_f, axis_f, unit_set, unit_g;
  health_t             expected_q[$];
  int                  n_errors, n_requests, n_checked, n_final, n_rate_err, n_range_err;

  function new();
    nominal    = 10000;
    period_tol = 5000;
    target     = 100000;
    rate_tol   = 2500;
    limit_pct  = 5;
    n_samples  = '0;
    n_oob      = '0;
    last_stamp = '0;
    first_arr  = '0;
    last_arr   = '0;
    order_f    = 0;
    spacing_f  = 0;
    axis_f     = 0;
    unit_set   = 0;
    unit_g     = 0;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_NOMINAL:    nominal    = value[PER_W-1:0];
      REG_PERIOD_TOL: period_tol = value[PER_W-1:0];
      REG_TARGET:     target     = value[RATE_W-1:0];
      REG_RATE_TOL:   rate_tol   = value[RATE_W-1:0];
      REG_LIMIT:      limit_pct  = value[PCT_W-1:0];
      default: ;
    endcase
  endfunction

  // exact rate test: |(n-1)*1e9/dur - target| < tol, cross-multiplied by dur
  function bit rate_off();
    logic [127:0]       scaled_n, tgt, tol, gap;
    logic [STAMP_W-1:0] dur;
    scaled_n = (128'(n_samples) - 128'd1) * 128'(NS_SCALE);
    if (last_arr == first_arr) return 1'b1;
    if (last_arr > first_arr) begin
      dur = last_arr - first_arr;
      tgt = 128'(target) * 128'(dur);
      tol = 128'(rate_tol) * 128'(dur);
      gap = (scaled_n < tgt) ? tgt - scaled_n : scaled_n - tgt;
      return !(gap < tol);
    end
    // arrival went backwards: rate is negative
    dur = first_arr - last_arr;
    tgt = 128'(target) * 128'(dur);
    tol = 128'(rate_tol) * 128'(dur);
    return !((scaled_n + tgt) < tol);
  endfunction

  function logic [OUT_W-1:0] clip(logic [CNT_BITS-1:0] c);
    return (64'(c) > 64'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(c);
  endfunction

  function void note_request(imu_req_t r);
    health_t        h;
    logic [STAMP_W:0] step, dev;
    bit             first, oob;
    h = '0;
    n_requests++;
    if (r.op == OP_END) begin
      h.is_final = 1'b1;
      h.no_data  = (n_samples == 0);
      if (n_samples > 1) begin
        h.rate_error  = rate_off();
        h.range_error = (64'(n_oob) * 64'd100) > (64'(limit_pct) * 64'(n_samples));
      end
    end else begin
      first = (n_samples == 0);
      if (first) first_arr = r.arrival;
      last_arr = r.arrival;
      if (n_samples != '1) n_samples++;
      if (r.stamp < last_stamp) order_f = 1;
      if (last_stamp != 0) begin
        if (r.stamp >= last_stamp) begin
          step = {1'b0, r.stamp} - {1'b0, last_stamp};
          dev  = (step >= nominal) ? step - nominal : nominal - step;
        end else begin
          dev = ({1'b0, last_stamp} - {1'b0, r.stamp}) + nominal;
        end
        if (dev > period_tol) spacing_f = 1;
      end
      if (first) begin
        axis_f   = !r.orient_ok;
        unit_g   = (r.accel_z < Z_SPLIT);
        unit_set = 1;
      end
      if (unit_g) oob = (r.accel_z >= G_HI) || (r.accel_z <= G_LO);
      else        oob = (r.accel_z >= MS_HI) || (r.accel_z <= MS_LO);
      if (oob && n_oob != '1) n_oob++;
      last_stamp = r.stamp;
    end
    h.order_error   = order_f;
    h.spacing_error = spacing_f;
    h.axis_error    = axis_f;
    h.unit_known    = unit_set;
    h.unit_is_g     = unit_g;
    h.total_samples = clip(n_samples);
    h.out_of_band   = clip(n_oob);
    expected_q = {expected_q, h};
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  function void check_result(health_t got);
    health_t want;
    if (expected_q.size() == 0) begin
      $error("result arrived with no request outstanding");
      n_errors++;
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    if (got.is_final === 1'b1) n_final++;
    if (got.rate_error === 1'b1) n_rate_err++;
    if (got.range_error === 1'b1) n_range_err++;
    compare_field("is_final", want.is_final, got.is_final);
    compare_field("order_error", want.order_error, got.order_error);
    compare_field("spacing_error", want.spacing_error, got.spacing_error);
    compare_field("axis_error", want.axis_error, got.axis_error);
    compare_field("unit_known", want.unit_known, got.unit_known);
    compare_field("unit_is_g", want.unit_is_g, got.unit_is_g);
    compare_field("rate_error", want.rate_error, got.rate_error);
    compare_field("range_error", want.range_error, got.range_error);
    compare_field("no_data", want.no_data, got.no_data);
    compare_field("total_samples", want.total_samples, got.total_samples);
    compare_field("out_of_band", want.out_of_band, got.out_of_band);
  endfunction
endclass

module testbench;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RUN_LIMIT       = 2000000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata, prdata;
  logic                  in_valid, in_stall, op, orientation_ok;
  logic [STAMP_W-1:0]    stamp_us, arrival_us;
  logic signed [Z_W-1:0] accel_z_milli;
  logic                  out_valid, out_stall;
  logic                  is_final, order_error, spacing_error, axis_error;
  logic                  unit_known, unit_is_g, rate_error, range_error, no_data;
  logic [OUT_W-1:0]      total_samples, out_of_band;

  logic hold_pending = 1'b0;
  int   tx_idle_pct  = 7;
  int   rx_idle_pct  = 65;
  int   oob_pct      = 10;

  imu_health_scoreboard board;

  imu_stream_health_monitor DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [STAMP_W-1:0] rand_wide();
    return STAMP_W'({$urandom, $urandom});
  endfunction

  function automatic imu_req_t pack_req(op_e kind, logic [STAMP_W-1:0] stamp,
                                        logic [STAMP_W-1:0] arrival,
                                        logic signed [Z_W-1:0] z, logic ook);
    imu_req_t r;
    r.op        = kind;
    r.stamp     = stamp;
    r.arrival   = arrival;
    r.accel_z   = z;
    r.orient_ok = ook;
    return r;
  endfunction

  function automatic imu_req_t end_req();
    return pack_req(OP_END, rand_wide(), rand_wide(), Z_W'($urandom),
                    1'($urandom_range(1)));
  endfunction

  // well-formed samples step by nominal +/- tolerance and arrive near the
  // target rate; noisy ones jump anywhere
  function automatic imu_req_t make_sample(bit noisy);
    imu_req_t r;
    longint   jit, span, skew;
    int       lo, hi, tol;
    r.op        = OP_SAMPLE;
    r.orient_ok = 1'($urandom_range(1));
    lo = board.unit_g ? G_LO : MS_LO;
    hi = board.unit_g ? G_HI : MS_HI;
    if (noisy) begin
      case ($urandom_range(3))
        0:       r.stamp = rand_wide();
        1:       r.stamp = board.last_stamp - STAMP_W'($urandom_range(1, 1000));
        2:       r.stamp = '1;
        default: r.stamp = '0;
      endcase
      case ($urandom_range(3))
        0:       r.arrival = '1;
        1:       r.arrival = '0;
        default: r.arrival = rand_wide();
      endcase
      r.accel_z = Z_W'($urandom);
      return r;
    end
    tol = int'(board.period_tol);
    case ($urandom_range(9))
      0:       jit = tol;
      1:       jit = -tol;
      2:       jit = ($urandom_range(299) == 0) ? tol + 1 : 0;
      default: jit = longint'($urandom_range(2 * tol)) - tol;
    endcase
    r.stamp = board.last_stamp + STAMP_W'(longint'(board.nominal) + jit);
    span = longint'(board.n_samples) * NS_SCALE / longint'(board.target);
    skew = longint'($urandom_range(80)) - 40;
    r.arrival = board.first_arr + STAMP_W'(span * (1000 + skew) / 1000);
    if ($urandom_range(99) < oob_pct) begin
      case ($urandom_range(3))
        0:       r.accel_z = Z_W'(hi);
        1:       r.accel_z = Z_W'(lo);
        2:       r.accel_z = Z_W'(hi + int'($urandom_range(20000)));
        default: r.accel_z = Z_W'(lo - int'($urandom_range(20000)));
      endcase
    end else begin
      case ($urandom_range(3))
        0:       r.accel_z = Z_W'(lo + 1);
        1:       r.accel_z = Z_W'(hi - 1);
        default: r.accel_z = Z_W'(lo + 1 + int'($urandom_range(hi - lo - 2)));
      endcase
    end
    return r;
  endfunction

  task automatic send(input imu_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= r.op;
    stamp_us       <= r.stamp;
    arrival_us     <= r.arrival;
    accel_z_milli  <= r.accel_z;
    orientation_ok <= r.orient_ok;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), value, prdata);
      board.n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_config(input logic [PER_W-1:0] nom, input logic [PER_W-1:0] tol,
                                input logic [RATE_W-1:0] tgt, input logic [RATE_W-1:0] rtol,
                                input logic [PCT_W-1:0] lim);
    drain();
    write_reg(REG_NOMINAL, DATA_W'(nom));
    write_reg(REG_PERIOD_TOL, DATA_W'(tol));
    write_reg(REG_TARGET, DATA_W'(tgt));
    write_reg(REG_RATE_TOL, DATA_W'(rtol));
    write_reg(REG_LIMIT, DATA_W'(lim));
  endtask

  // result side: random stall plus one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        out_stall    <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(health_t'({is_final, order_error, spacing_error, axis_error,
                                    unit_known, unit_is_g, rate_error, range_error,
                                    no_data, total_samples, out_of_band}));
  end

  initial begin : stimulus
    logic [PER_W-1:0]  nom_cfg, tol_cfg;
    logic [RATE_W-1:0] tgt_cfg, rtol_cfg;
    logic [PCT_W-1:0]  lim_cfg;
    int                since_end, batch_len;
    board          = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    op             = OP_SAMPLE;
    stamp_us       = '0;
    arrival_us     = '0;
    accel_z_milli  = '0;
    orientation_ok = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings: nominal 10000, tolerance 5000, target 100000 mHz
    send(end_req());                                       // nothing seen yet
    send(pack_req(OP_SAMPLE, 0, 1000, 5500, 1'b0));        // tie picks m/s^2, no orientation
    send(end_req());                                       // single sample
    send(pack_req(OP_SAMPLE, 3, 1000, 12250, 1'b1));       // previous stamp zero: no spacing test
    send(end_req());                                       // zero duration
    send(pack_req(OP_SAMPLE, 15003, 500, 7351, 1'b1));     // deviation at tolerance, arrival back
    send(end_req());                                       // negative duration
    send(pack_req(OP_SAMPLE, 20003, 31000, 12249, 1'b1));  // rate exactly on target
    send(end_req());
    send(pack_req(OP_SAMPLE, 30003, '1, -8388608, 1'b0));
    send(pack_req(OP_SAMPLE, 40003, 0, 8388607, 1'b1));
    send(end_req());

    program_config(1, 0, 1, 0, 0);
    send(pack_req(OP_SAMPLE, 40004, 2000, 7350, 1'b1));
    send(end_req());

    program_config(1000000, 1000000, 10000000, 10000000, 100);
    send(pack_req(OP_SAMPLE, 40004, 3000, 10000, 1'b0));   // equal stamps
    send(pack_req(OP_SAMPLE, 2040004, 4000, 0, 1'b1));
    send(end_req());

    // two phases per idle pattern, fresh settings for each
    for (int p = 0; p < 6; p++) begin
      nom_cfg  = PER_W'($urandom_range(50, 100000));
      tol_cfg  = PER_W'($urandom_range(0, nom_cfg / 4));
      tgt_cfg  = RATE_W'($urandom_range(10000, 10000000));
      rtol_cfg = RATE_W'(tgt_cfg / 1000 * $urandom_range(5, 40));
      lim_cfg  = PCT_W'($urandom_range(0, 100));
      program_config(nom_cfg, tol_cfg, tgt_cfg, rtol_cfg, lim_cfg);
      oob_pct     = $urandom_range(0, 40);
      tx_idle_pct = (p < 2) ? 7 : (p < 4) ? 65 : 0;
      rx_idle_pct = (p < 2) ? 65 : (p < 4) ? 7 : 0;
      since_end   = 0;
      batch_len   = $urandom_range(1, 40);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 0 && i == 60) hold_pending <= 1'b1;
        if (since_end >= batch_len) begin
          send(end_req());
          since_end = 0;
          batch_len = $urandom_range(1, 40);
        end else begin
          send(make_sample((p == 3 || p == 5) && $urandom_range(99) < 10));
          since_end++;
        end
      end
    end

    drain();
    $display("covered %0d requests, %0d results checked, %0d of them end-of-stream",
             board.n_requests, board.n_checked, board.n_final);
    $display("flags order=%0b spacing=%0b axis=%0b g=%0b; rate errors %0d, range errors %0d",
             board.order_f, board.spacing_f, board.axis_f, board.unit_g,
             board.n_rate_err, board.n_range_err);
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", board.expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
